// ----- rtl/core/cswin_pkg.sv -----
`timescale 1ns / 1ps

package cswin_pkg;

    localparam int MAX_CHUNKS = 1024;
    localparam int IDX_W      = $clog2(MAX_CHUNKS);
    localparam int CNT_W      = 11;
    localparam int FLIGHT_W   = 7;
    localparam int TMO_W      = 16;
    localparam int TIME_W     = 32;
    localparam int CMD_W      = 2;

    // Bitmaps are held as rows of ROW_BITS chunks.
    localparam int ROW_BITS   = 32;
    localparam int BIT_AW     = $clog2(ROW_BITS);
    localparam int ROWS       = MAX_CHUNKS / ROW_BITS;
    localparam int ROW_AW     = $clog2(ROWS);

    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 40;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_TOTAL      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_FLIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT    = 2'd2;

    localparam logic [CNT_W-1:0]    TOTAL_RST   = 11'd0;
    localparam logic [FLIGHT_W-1:0] FLIGHT_RST  = 7'd1;
    localparam logic [TMO_W-1:0]    TIMEOUT_RST = 16'd10;

    typedef enum logic [CMD_W-1:0] {
        CMD_REQUEST    = 2'd0,
        CMD_MARK_SENT  = 2'd1,
        CMD_MARK_ACKED = 2'd2,
        CMD_NAME_ACK   = 2'd3
    } t_cmd_e;

    typedef struct packed {
        t_cmd_e              cmd;
        logic [IDX_W-1:0]    idx;
        logic                flag;
        logic [TIME_W-1:0]   now;
        logic                idx_err;
    } t_item;

    typedef struct packed {
        logic pop;
        logic clearing;
    } t_back_ctl;

    typedef struct packed {
        logic               chunk_valid;
        logic [IDX_W-1:0]   chunk_out;
        logic               is_resend;
        logic               index_error;
        logic [CNT_W-1:0]   sent_count;
        logic [CNT_W-1:0]   acked_count;
        logic               done_res;
    } t_result;

endpackage

// ----- rtl/core/cswin_ram.sv -----
`timescale 1ns / 1ps

module cswin_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/cswin_front.sv -----
`timescale 1ns / 1ps

module cswin_front
    import cswin_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [IN_DATA_W-1:0] i_s_tdata,
    input  logic [CMD_W-1:0]     i_s_tuser,
    input  logic [CNT_W-1:0]     i_total,
    input  t_back_ctl            i_ctl,
    output logic                 o_q_valid,
    output t_item                o_q_item
);

    localparam int QDEPTH = 2;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    t_item               r_q [QDEPTH];
    logic                r_wr_ptr, n_wr_ptr;
    logic                r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0]   r_count, n_count;
    logic                w_accept;
    t_item               w_item;

    // Range check is done here so the back end only sees a ready-made flag.
    always_comb begin
        w_item.cmd     = t_cmd_e'(i_s_tuser);
        w_item.idx     = i_s_tdata[IDX_W-1:0];
        w_item.flag    = i_s_tdata[IDX_W];
        w_item.now     = i_s_tdata[IDX_W+1 +: TIME_W];
        w_item.idx_err = ((w_item.cmd == CMD_MARK_SENT) || (w_item.cmd == CMD_MARK_ACKED))
                         && (CNT_W'(w_item.idx) >= i_total);
    end

    assign o_s_tready = (r_count != QCNT_W'(QDEPTH)) && !i_ctl.clearing;
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign o_q_valid  = (r_count != '0);
    assign o_q_item   = r_q[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr ^ w_accept;
        n_rd_ptr = r_rd_ptr ^ i_ctl.pop;
        n_count  = r_count + QCNT_W'(w_accept) - QCNT_W'(i_ctl.pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_q[r_wr_ptr] <= w_item;
        end
    end

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.pop |-> (r_count != '0))
        else $error("back end popped an empty queue");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QDEPTH))
        else $error("queue fill count out of range");

    a_no_accept_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.clearing |-> !w_accept)
        else $error("request accepted while the bitmaps were being cleared");

endmodule

// ----- rtl/core/cswin_back.sv -----
`timescale 1ns / 1ps

module cswin_back
    import cswin_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  t_item               i_q_item,
    input  logic [CNT_W-1:0]    i_total,
    input  logic [FLIGHT_W-1:0] i_max_flight,
    input  logic [TMO_W-1:0]    i_timeout,
    input  logic                i_m_tready,
    output t_back_ctl           o_ctl,
    output logic                o_m_valid,
    output t_result             o_result
);

    typedef enum logic [7:0] {
        S_CLEAR    = 8'b0000_0001,
        S_IDLE     = 8'b0000_0010,
        S_DECIDE   = 8'b0000_0100,
        S_RMW_RD   = 8'b0000_1000,
        S_RMW_WR   = 8'b0001_0000,
        S_SCAN_RD  = 8'b0010_0000,
        S_SCAN_CHK = 8'b0100_0000,
        S_OUT      = 8'b1000_0000
    } t_state_e;

    typedef enum logic [1:0] {
        SCAN_NEW    = 2'd0,
        SCAN_UP     = 2'd1,
        SCAN_WRAP   = 2'd2
    } t_scan_e;

    typedef struct packed {
        logic             chunk_valid;
        logic [IDX_W-1:0] chunk_out;
        logic             is_resend;
        logic             index_error;
    } t_prop;

    t_state_e            r_state, n_state;
    t_scan_e             r_mode, n_mode;
    logic [ROW_AW-1:0]   r_row, n_row;
    logic [CNT_W-1:0]    r_from, n_from;
    t_item               r_item, n_item;
    t_prop               r_prop, n_prop;
    logic [CNT_W-1:0]    r_sent_total, n_sent_total;
    logic [CNT_W-1:0]    r_acked_total, n_acked_total;
    logic [CNT_W-1:0]    r_next_new, n_next_new;
    logic [CNT_W-1:0]    r_cursor, n_cursor;
    logic [TIME_W-1:0]   r_last_send, n_last_send;
    logic                r_name_acked, n_name_acked;
    logic                r_out_valid, n_out_valid;
    t_result             r_out, n_out;

    logic [ROW_BITS-1:0] w_sent_rdata, w_acked_rdata;
    logic [ROW_BITS-1:0] w_map_word, w_wdata, w_busy, w_lo_set, w_hi_keep;
    logic                w_sent_we, w_acked_we;
    logic [CNT_W-1:0]    w_total_m1, w_from_up;
    logic [ROW_AW-1:0]   w_last_row;
    logic [BIT_AW-1:0]   w_last_bit, w_hit_bit;
    logic                w_hit;
    logic [IDX_W-1:0]    w_hit_idx;
    logic signed [CNT_W:0] w_flight, w_max_s;
    logic                w_flight_ok, w_tmo_ok;
    logic [TIME_W-1:0]   w_elapsed;
    logic                w_bit_set;

    cswin_ram #(.WIDTH(ROW_BITS), .DEPTH(ROWS)) u_sent_map (
        .i_clk   (i_clk),
        .i_we    (w_sent_we),
        .i_waddr (r_row),
        .i_wdata (w_wdata),
        .i_raddr (r_row),
        .o_rdata (w_sent_rdata)
    );

    cswin_ram #(.WIDTH(ROW_BITS), .DEPTH(ROWS)) u_acked_map (
        .i_clk   (i_clk),
        .i_we    (w_acked_we),
        .i_waddr (r_row),
        .i_wdata (w_wdata),
        .i_raddr (r_row),
        .o_rdata (w_acked_rdata)
    );

    assign w_total_m1 = i_total - CNT_W'(1);
    assign w_last_row = w_total_m1[IDX_W-1:BIT_AW];
    assign w_last_bit = w_total_m1[BIT_AW-1:0];
    assign w_from_up  = r_cursor + CNT_W'(1);

    assign w_flight    = signed'({1'b0, r_sent_total}) - signed'({1'b0, r_acked_total});
    assign w_max_s     = signed'({{(CNT_W + 1 - FLIGHT_W){1'b0}}, i_max_flight});
    assign w_flight_ok = (w_flight <= w_max_s);

    // A negative elapsed time (stamp ahead of now) never allows a resend.
    assign w_elapsed = r_item.now - r_last_send;
    assign w_tmo_ok  = !w_elapsed[TIME_W-1] && (w_elapsed > TIME_W'(i_timeout));

    // Scan and read-modify-write both look at the map chosen by the command or scan mode.
    always_comb begin
        if (r_state == S_RMW_WR) begin
            w_map_word = (r_item.cmd == CMD_MARK_SENT) ? w_sent_rdata : w_acked_rdata;
        end else begin
            w_map_word = (r_mode == SCAN_NEW) ? w_sent_rdata : w_acked_rdata;
        end
    end

    assign w_bit_set = w_map_word[r_item.idx[BIT_AW-1:0]];
    assign w_wdata   = (r_state == S_CLEAR) ? '0
                     : (w_map_word | (ROW_BITS'(1) << r_item.idx[BIT_AW-1:0]));
    assign w_sent_we  = (r_state == S_CLEAR)
                     || ((r_state == S_RMW_WR) && (r_item.cmd == CMD_MARK_SENT));
    assign w_acked_we = (r_state == S_CLEAR)
                     || ((r_state == S_RMW_WR) && (r_item.cmd == CMD_MARK_ACKED));

    // Chunks below the scan start and at or above the total count as taken.
    assign w_lo_set  = ~({ROW_BITS{1'b1}} << r_from[BIT_AW-1:0]);
    assign w_hi_keep = {ROW_BITS{1'b1}} >> (BIT_AW'(ROW_BITS - 1) - w_last_bit);

    always_comb begin
        w_busy = w_map_word;
        if (r_row == r_from[IDX_W-1:BIT_AW]) begin
            w_busy = w_busy | w_lo_set;
        end
        if (r_row == w_last_row) begin
            w_busy = w_busy | ~w_hi_keep;
        end
    end

    always_comb begin
        w_hit     = 1'b0;
        w_hit_bit = '0;
        for (int i = ROW_BITS - 1; i >= 0; i--) begin
            if (!w_busy[i]) begin
                w_hit     = 1'b1;
                w_hit_bit = BIT_AW'(i);
            end
        end
    end

    assign w_hit_idx = {r_row, w_hit_bit};

    always_comb begin
        n_state       = r_state;
        n_mode        = r_mode;
        n_row         = r_row;
        n_from        = r_from;
        n_item        = r_item;
        n_prop        = r_prop;
        n_sent_total  = r_sent_total;
        n_acked_total = r_acked_total;
        n_next_new    = r_next_new;
        n_cursor      = r_cursor;
        n_last_send   = r_last_send;
        n_name_acked  = r_name_acked;
        n_out_valid   = r_out_valid && !i_m_tready;
        n_out         = r_out;
        o_ctl.pop      = 1'b0;
        o_ctl.clearing = (r_state == S_CLEAR);

        unique case (r_state)
            S_CLEAR: begin
                n_row = r_row + ROW_AW'(1);
                if (r_row == ROW_AW'(ROWS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_q_valid) begin
                    o_ctl.pop = 1'b1;
                    n_item    = i_q_item;
                    n_prop    = '0;
                    n_state   = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_state = S_OUT;
                unique case (r_item.cmd) inside
                    CMD_REQUEST: begin
                        if (r_acked_total < i_total) begin
                            if (w_flight_ok) begin
                                if (r_next_new >= i_total) begin
                                    n_mode  = SCAN_NEW;
                                    n_from  = '0;
                                    n_row   = '0;
                                    n_state = S_SCAN_RD;
                                end else begin
                                    n_prop.chunk_valid = 1'b1;
                                    n_prop.chunk_out   = r_next_new[IDX_W-1:0];
                                    n_next_new         = r_next_new + CNT_W'(1);
                                end
                            end else if (w_tmo_ok) begin
                                n_state = S_SCAN_RD;
                                if (w_from_up < i_total) begin
                                    n_mode = SCAN_UP;
                                    n_from = w_from_up;
                                    n_row  = w_from_up[IDX_W-1:BIT_AW];
                                end else begin
                                    n_mode = SCAN_WRAP;
                                    n_from = '0;
                                    n_row  = '0;
                                end
                            end
                        end
                    end
                    CMD_MARK_SENT, CMD_MARK_ACKED: begin
                        if (r_item.idx_err) begin
                            n_prop.index_error = 1'b1;
                        end else begin
                            n_row   = r_item.idx[IDX_W-1:BIT_AW];
                            n_state = S_RMW_RD;
                        end
                    end
                    CMD_NAME_ACK: begin
                        n_name_acked = r_item.flag;
                    end
                    default: begin
                        n_state = S_OUT;
                    end
                endcase
            end
            S_RMW_RD: begin
                n_state = S_RMW_WR;
            end
            S_RMW_WR: begin
                if (r_item.cmd == CMD_MARK_SENT) begin
                    n_last_send = r_item.now;
                    if (!w_bit_set) begin
                        n_sent_total = r_sent_total + CNT_W'(1);
                    end
                end else if (!w_bit_set) begin
                    n_acked_total = r_acked_total + CNT_W'(1);
                end
                n_state = S_OUT;
            end
            S_SCAN_RD: begin
                n_state = S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
                if (w_hit) begin
                    n_prop.chunk_valid = 1'b1;
                    n_prop.chunk_out   = w_hit_idx;
                    if (r_mode == SCAN_NEW) begin
                        n_next_new = CNT_W'(w_hit_idx) + CNT_W'(1);
                    end else begin
                        n_cursor         = CNT_W'(w_hit_idx);
                        n_prop.is_resend = 1'b1;
                    end
                    n_state = S_OUT;
                end else if (r_row != w_last_row) begin
                    n_row   = r_row + ROW_AW'(1);
                    n_state = S_SCAN_RD;
                end else begin
                    n_state = S_OUT;
                    case (r_mode)
                        SCAN_NEW: begin
                            n_next_new = i_total;
                        end
                        SCAN_UP: begin
                            // Nothing after the cursor: wrap round to the first chunk.
                            n_mode  = SCAN_WRAP;
                            n_from  = '0;
                            n_row   = '0;
                            n_state = S_SCAN_RD;
                        end
                        default: begin
                            n_state = S_OUT;
                        end
                    endcase
                end
            end
            S_OUT: begin
                if (!r_out_valid || i_m_tready) begin
                    n_out.chunk_valid = r_prop.chunk_valid;
                    n_out.chunk_out   = r_prop.chunk_out;
                    n_out.is_resend   = r_prop.is_resend;
                    n_out.index_error = r_prop.index_error;
                    n_out.sent_count  = r_sent_total;
                    n_out.acked_count = r_acked_total;
                    n_out.done_res    = (r_acked_total >= i_total) && r_name_acked;
                    n_out_valid       = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_mode        <= SCAN_NEW;
            r_row         <= '0;
            r_sent_total  <= '0;
            r_acked_total <= '0;
            r_next_new    <= '0;
            r_cursor      <= '0;
            r_last_send   <= '0;
            r_name_acked  <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_mode        <= n_mode;
            r_row         <= n_row;
            r_sent_total  <= n_sent_total;
            r_acked_total <= n_acked_total;
            r_next_new    <= n_next_new;
            r_cursor      <= n_cursor;
            r_last_send   <= n_last_send;
            r_name_acked  <= n_name_acked;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_from <= n_from;
        r_item <= n_item;
        r_prop <= n_prop;
        r_out  <= n_out;
    end

    assign o_m_valid = r_out_valid;
    assign o_result  = r_out;

    a_sent_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sent_total <= CNT_W'(MAX_CHUNKS))
        else $error("sent count exceeds chunk capacity");

    a_acked_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_acked_total <= CNT_W'(MAX_CHUNKS))
        else $error("acknowledged count exceeds chunk capacity");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN_RD) |-> (r_row <= w_last_row))
        else $error("bitmap scan ran past the last row");

    a_result_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_OUT))
        else $error("result presented outside the output state");

endmodule

// ----- rtl/core/chunk_send_window_scheduler.sv -----
`timescale 1ns / 1ps

// Sender-side chunk scheduler with selective-repeat resend.
// Commands enter on the s_axis channel (command in tuser); each command
// yields exactly one result on the m_axis channel, in order. Registers
// total_chunks, max_in_flight and resend_timeout are written through the
// cfg channel (index 0, 1, 2), which is always ready; write them only while
// no command is outstanding.
// A two-entry queue lets the input side accept commands while the back end
// is busy or the result register waits. A plain request or name flag passes
// through the decide and output states to the result register; an in-range
// mark sent or mark acknowledged adds a read and a write state (one
// read-modify-write of a 32-chunk bitmap row). Requests that must search a
// bitmap add a read and a check state per 32-chunk row visited; a wrapped
// resend search can visit every row twice. This single back end takes one
// command at a time from the queue. After reset both bitmaps are cleared,
// one row per cycle, while s_axis_tready is low. If m_axis_tready stays
// low, one result waits in the output register, the queue fills and
// s_axis_tready drops.
module chunk_send_window_scheduler
    import cswin_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // chunk_index [9:0], flag_value [10], now_ms [42:11], zero [47:43]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // command [1:0]
    input  logic [CMD_W-1:0]      s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // chunk_valid [0], chunk_out [10:1], index_error [11], sent_count [22:12],
    // acked_count [33:23], done_res [34], zero [39:35]
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // is_resend [0]
    output logic                  m_axis_tuser,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [CNT_W-1:0]    r_total;
    logic [FLIGHT_W-1:0] r_max_flight;
    logic [TMO_W-1:0]    r_timeout;
    logic [CNT_W-1:0]    w_eff_total;
    t_back_ctl           w_ctl;
    logic                w_q_valid;
    t_item               w_q_item;
    t_result             w_result;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total      <= TOTAL_RST;
            r_max_flight <= FLIGHT_RST;
            r_timeout    <= TIMEOUT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_TOTAL:      r_total      <= i_cfg_data[CNT_W-1:0];
                REG_MAX_FLIGHT: r_max_flight <= i_cfg_data[FLIGHT_W-1:0];
                REG_TIMEOUT:    r_timeout    <= i_cfg_data[TMO_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Totals above the bitmap size behave as the bitmap size.
    assign w_eff_total = (r_total > CNT_W'(MAX_CHUNKS)) ? CNT_W'(MAX_CHUNKS) : r_total;

    cswin_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_s_tdata  (s_axis_tdata),
        .i_s_tuser  (s_axis_tuser),
        .i_total    (w_eff_total),
        .i_ctl      (w_ctl),
        .o_q_valid  (w_q_valid),
        .o_q_item   (w_q_item)
    );

    cswin_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (w_q_valid),
        .i_q_item     (w_q_item),
        .i_total      (w_eff_total),
        .i_max_flight (r_max_flight),
        .i_timeout    (r_timeout),
        .i_m_tready   (m_axis_tready),
        .o_ctl        (w_ctl),
        .o_m_valid    (m_axis_tvalid),
        .o_result     (w_result)
    );

    assign m_axis_tdata = {
        (OUT_DATA_W - 35)'(0),
        w_result.done_res,
        w_result.acked_count,
        w_result.sent_count,
        w_result.index_error,
        w_result.chunk_out,
        w_result.chunk_valid
    };
    assign m_axis_tuser = w_result.is_resend;

endmodule
